// ===== design/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// aes_pkg
// shared types, s-box table and round helpers for the aes-128 encrypt unit
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int ROUND_COUNT = 10;
    localparam int KEY_WORDS   = 44;

    typedef logic [127:0] block_t;
    typedef logic [31:0]  word_t;
    typedef logic [7:0]   byte_t;

    localparam logic [0:0] REG_KEY_HIGH = 1'b0;
    localparam logic [0:0] REG_KEY_LOW  = 1'b1;

    localparam byte_t SBOX_TAB [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam byte_t RCON_TAB [10] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    function automatic word_t sub_word(input word_t w);
        sub_word = {SBOX_TAB[w[31:24]], SBOX_TAB[w[23:16]],
                    SBOX_TAB[w[15:8]], SBOX_TAB[w[7:0]]};
    endfunction

    function automatic byte_t xtime(input byte_t b);
        xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic word_t mix_column(input word_t w);
        byte_t a0, a1, a2, a3;
        a0 = w[31:24];
        a1 = w[23:16];
        a2 = w[15:8];
        a3 = w[7:0];
        mix_column = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                      a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                      a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                      xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
    endfunction

    // subbytes plus shiftrows on a column-major block, word 0 in the top bits
    function automatic block_t sub_shift(input block_t s);
        block_t t;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[127 - 32*c - 8*r -: 8] = SBOX_TAB[s[127 - 32*((c + r) % 4) - 8*r -: 8]];
            end
        end
        sub_shift = t;
    endfunction

endpackage

// ===== design/aes_key_expand.sv =====
// ----------------------------------------------------------------------------
// aes_key_expand
// expands the cipher key into 11 round keys, one round key per cycle
// ----------------------------------------------------------------------------
module aes_key_expand
    import aes_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  block_t       key,
    output logic         busy,
    output block_t       round_keys [ROUND_COUNT + 1]
);

    logic [3:0] cnt_reg, cnt_next;
    block_t     rk_reg [ROUND_COUNT + 1];
    block_t     prev;
    block_t     nxt;
    word_t      tw;

    always_comb
    begin
        prev = rk_reg[cnt_reg - 4'd1];
        tw   = sub_word({prev[23:0], prev[31:24]}) ^ {RCON_TAB[cnt_reg - 4'd1], 24'h0};
        nxt[127:96] = prev[127:96] ^ tw;
        nxt[95:64]  = prev[95:64] ^ nxt[127:96];
        nxt[63:32]  = prev[63:32] ^ nxt[95:64];
        nxt[31:0]   = prev[31:0] ^ nxt[63:32];
        cnt_next = cnt_reg;
        if (start)
            cnt_next = 4'd1;
        else if (cnt_reg != 4'd0)
            cnt_next = (cnt_reg == 4'(ROUND_COUNT)) ? 4'd0 : cnt_reg + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 4'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (start)
            rk_reg[0] <= key;
        else if (cnt_reg != 4'd0)
            rk_reg[cnt_reg] <= nxt;
    end

    assign busy       = (cnt_reg != 4'd0);
    assign round_keys = rk_reg;

    cnt_range_a: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 4'(ROUND_COUNT)) else $error("key counter out of range");
    cnt_step_a: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && !start && cnt_reg != 4'(ROUND_COUNT)) |=> cnt_reg == $past(cnt_reg) + 4'd1)
        else $error("key counter skipped");

endmodule

// ===== design/aes_round_stage.sv =====
// ----------------------------------------------------------------------------
// aes_round_stage
// one registered cipher round with its own valid bit and stall enable
// ----------------------------------------------------------------------------
module aes_round_stage
    import aes_pkg::*;
#(
    parameter bit LAST = 1'b0
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   in_valid,
    input  block_t in_state,
    input  block_t rkey,
    output logic   out_valid,
    output block_t out_state
);

    logic   valid_reg;
    block_t state_reg;
    block_t t;
    block_t m;

    always_comb
    begin
        t = sub_shift(in_state);
        for (int c = 0; c < 4; c++)
        begin
            m[127 - 32*c -: 32] = LAST ? t[127 - 32*c -: 32] : mix_column(t[127 - 32*c -: 32]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            state_reg <= m ^ rkey;
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;

endmodule

// ===== design/aes128_block_encrypt_unit.sv =====
// ----------------------------------------------------------------------------
// aes128_block_encrypt_unit
// fully unrolled aes-128 encryption pipeline with stream ports
// ----------------------------------------------------------------------------
// one block enters per cycle unless the pipe is halted or the key expander is
// busy; the pipe holds an initial addroundkey register plus ten round registers,
// one per unrolled round stage. the whole pipe advances together and halts when
// the output register holds a result that is not taken, so nothing is lost or
// repeated. a key write restarts the key expander, which makes one round key a
// cycle; during that time the block accepts no request. config writes must only
// be issued while the pipe is empty; the block itself does not enforce this.
module aes128_block_encrypt_unit
    import aes_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // config write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    // input stream, tdata: plain_high [63:0], plain_low [127:64]
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,
    // output stream, tdata: cipher_high [63:0], cipher_low [127:64]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata
);

    logic [63:0] key_high_reg, key_low_reg;
    logic        cfg_fire;
    logic        kx_start;
    logic        kx_busy;
    block_t      rkeys [ROUND_COUNT + 1];
    logic        en;
    logic        v0_reg;
    block_t      s0_reg;
    logic        vld [ROUND_COUNT + 1];
    block_t      st  [ROUND_COUNT + 1];
    logic [63:0] key_high_new, key_low_new;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // a write takes effect on the expander start together with the new value
    assign key_high_new = (cfg_fire && cfg_index == REG_KEY_HIGH) ? cfg_data : key_high_reg;
    assign key_low_new  = (cfg_fire && cfg_index == REG_KEY_LOW)  ? cfg_data : key_low_reg;
    assign kx_start     = cfg_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= 64'h0;
            key_low_reg  <= 64'h0;
        end
        else
        begin
            key_high_reg <= key_high_new;
            key_low_reg  <= key_low_new;
        end
    end

    aes_key_expand u_kx
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (kx_start),
        .key        ({key_high_new, key_low_new}),
        .busy       (kx_busy),
        .round_keys (rkeys)
    );

    // whole pipe moves when the output slot is free or empty
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en && !kx_busy && !kx_start;

    // stage 0: initial addroundkey
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= s_tvalid && s_tready;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s0_reg <= {s_tdata[63:0], s_tdata[127:64]} ^ rkeys[0];
    end

    assign vld[0] = v0_reg;
    assign st[0]  = s0_reg;

    for (genvar r = 1; r <= ROUND_COUNT; r++)
    begin : g_round
        aes_round_stage #(.LAST(r == ROUND_COUNT)) u_rnd
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (vld[r - 1]),
            .in_state  (st[r - 1]),
            .rkey      (rkeys[r]),
            .out_valid (vld[r]),
            .out_state (st[r])
        );
    end

    assign m_tvalid = vld[ROUND_COUNT];
    assign m_tdata  = {st[ROUND_COUNT][63:0], st[ROUND_COUNT][127:64]};

    hold_a: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");
    no_accept_kx_a: assert property (@(posedge clk) disable iff (!rst_n)
        kx_busy |-> !s_tready) else $error("request accepted during key expansion");
    enter_a: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> v0_reg) else $error("accepted request lost");

endmodule

// ===== bench/aes128_block_encrypt_unit_tb.sv =====
// ----------------------------------------------------------------------------
// aes128_block_encrypt_unit_tb
// self-checking bench for the aes-128 encrypt unit: each accepted plaintext
// block is encrypted by a bench-side model under the current key and queued;
// every ciphertext leaving the unit is checked against the oldest entry
// ----------------------------------------------------------------------------
module aes128_block_encrypt_unit_tb;
    import aes_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // ------------------------------------------------------------------------
    // cipher model and expected ciphertext store
    // ------------------------------------------------------------------------
    class cipher_scoreboard;
        logic [63:0]  key_hi;
        logic [63:0]  key_lo;
        word_t        sched [KEY_WORDS];
        logic [127:0] cipher_q [$];
        int           errors;

        function new();
            key_hi = '0;
            key_lo = '0;
            errors = 0;
            foreach (sched[i]) sched[i] = '0;
        endfunction

        function byte_t dbl(byte_t b);
            return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
        endfunction

        function word_t mix(word_t w);
            byte_t a0, a1, a2, a3;
            a0 = w[31:24];
            a1 = w[23:16];
            a2 = w[15:8];
            a3 = w[7:0];
            return {dbl(a0) ^ dbl(a1) ^ a1 ^ a2 ^ a3,
                    a0 ^ dbl(a1) ^ dbl(a2) ^ a2 ^ a3,
                    a0 ^ a1 ^ dbl(a2) ^ dbl(a3) ^ a3,
                    dbl(a0) ^ a0 ^ a1 ^ a2 ^ dbl(a3)};
        endfunction

        // a write to either half re-expands using the other half as held
        function void write_key(logic [0:0] idx, logic [63:0] val);
            word_t t;
            if (idx == REG_KEY_HIGH)
                key_hi = val;
            else
                key_lo = val;
            sched[0] = key_hi[63:32];
            sched[1] = key_hi[31:0];
            sched[2] = key_lo[63:32];
            sched[3] = key_lo[31:0];
            for (int i = 4; i < KEY_WORDS; i++)
            begin
                t = sched[i-1];
                if (i % 4 == 0)
                begin
                    t = {t[23:0], t[31:24]};
                    t = {SBOX_TAB[t[31:24]], SBOX_TAB[t[23:16]],
                         SBOX_TAB[t[15:8]], SBOX_TAB[t[7:0]]};
                    t[31:24] = t[31:24] ^ RCON_TAB[i/4 - 1];
                end
                sched[i] = sched[i-4] ^ t;
            end
        endfunction

        // note an accepted plaintext request
        function void note_block(logic [127:0] tdata);
            word_t s [4];
            word_t t [4];
            s[0] = tdata[63:32];
            s[1] = tdata[31:0];
            s[2] = tdata[127:96];
            s[3] = tdata[95:64];
            for (int c = 0; c < 4; c++) s[c] ^= sched[c];
            for (int r = 1; r <= ROUND_COUNT; r++)
            begin
                for (int c = 0; c < 4; c++)
                    for (int w = 0; w < 4; w++)
                        t[c][31-8*w -: 8] = SBOX_TAB[s[(c+w)%4][31-8*w -: 8]];
                for (int c = 0; c < 4; c++)
                    s[c] = ((r < ROUND_COUNT) ? mix(t[c]) : t[c]) ^ sched[4*r + c];
            end
            cipher_q.push_back({s[2], s[3], s[0], s[1]});
        endfunction

        function void check_result(logic [127:0] tdata);
            logic [127:0] exp_data;
            if (cipher_q.size() == 0)
            begin
                $error("unexpected ciphertext %h", tdata);
                errors++;
                return;
            end
            exp_data = cipher_q.pop_front();
            if (tdata[63:0] !== exp_data[63:0])
            begin
                $error("cipher_high expected %h actual %h", exp_data[63:0], tdata[63:0]);
                errors++;
            end
            if (tdata[127:64] !== exp_data[127:64])
            begin
                $error("cipher_low expected %h actual %h", exp_data[127:64], tdata[127:64]);
                errors++;
            end
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PIPE_LATENCY   = 11;

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [0:0]   cfg_index;
    logic [63:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;

    cipher_scoreboard sb;
    bit  calm;          // when set, neither side idles
    int  quiet_cycles;  // cycles with no request moved anywhere

    aes128_block_encrypt_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // ------------------------------------------------------------------------
    // output side: random back-pressure, checking of every taken result
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 9);
    end

    // watchdog: ends the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // key register write request; only issued with the pipe empty
    task automatic write_key_reg(logic [0:0] idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_key(idx, val);
        cfg_valid <= 1'b0;
    endtask

    // cfg_valid drops between the two writes, keeping it to one update a step
    task automatic load_key(logic [63:0] hi, logic [63:0] lo);
        write_key_reg(REG_KEY_HIGH, hi);
        @(posedge clk);
        write_key_reg(REG_KEY_LOW, lo);
    endtask

    // plaintext request, with an occasional gap ahead of it
    task automatic send_block(logic [63:0] hi, logic [63:0] lo);
        if (!calm && $urandom_range(99) < 9)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {lo, hi};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_block({lo, hi});
    endtask

    // wait until every ciphertext is back, then let the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.cipher_q.size() != 0) @(posedge clk);
        repeat (PIPE_LATENCY + 4) @(posedge clk);
    endtask

    task automatic directed_set();
        send_block('0, '0);
        send_block('1, '1);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(64'h8000000000000000, 64'h0000000000000001);
        send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
        send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    endtask

    initial
    begin
        sb        = new();
        calm      = 1'b0;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: standard key, then the extreme keys
        load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
        directed_set();
        drain();
        load_key('0, '0);
        directed_set();
        drain();
        load_key('1, '1);
        directed_set();
        drain();
        // partial update: only the low half changes
        write_key_reg(REG_KEY_LOW, 64'h0123456789abcdef);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        drain();

        // random: new key per phase (only the high half in phase 4), one phase run flat out
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 4)
                write_key_reg(REG_KEY_HIGH, rand64());
            else
                load_key(rand64(), rand64());
            calm = (ph == 2);
            for (int n = 0; n < 120; n++)
                send_block(rand64(), rand64());
            drain();
        end
        calm = 1'b0;
        drain();

        if (sb.errors == 0 && sb.cipher_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/aes_pkg.sv
design/aes_key_expand.sv
design/aes_round_stage.sv
design/aes128_block_encrypt_unit.sv
bench/aes128_block_encrypt_unit_tb.sv
